// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define VIPS_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define VIPS_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/vips_pkg.sv -----
// ----------------------------------------------------------------------------
// vips_pkg
// Types and constants of the virtual interrupt priority select block.
// ----------------------------------------------------------------------------
package vips_pkg;

    localparam int NUM_ENTRIES = 32;
    localparam int ENT_AW      = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(NUM_ENTRIES + 1);

    localparam int KIND_W   = 2;
    localparam int IDX_W    = 5;
    localparam int VALUE_W  = 8;
    localparam int PROC_W   = 4;
    localparam int PRIO_W   = 8;
    localparam int ACTION_W = 2;
    localparam int WORD_W   = 32;
    localparam int BASE_W   = 10;
    localparam int VID_W    = BASE_W + 1;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_ADDR_W-1:0] CFG_FEATURE_ENABLE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PRIO_LIMIT     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPI_BASE       = 2'd2;

    localparam logic [PRIO_W-1:0] PRIO_MASK_RST = 8'd255;
    localparam logic [BASE_W-1:0] SPI_BASE_RST  = 10'd32;

    localparam int                LW_PRIO_SHIFT = 23;
    localparam logic [WORD_W-1:0] LW_PENDING    = 32'h1000_0000;
    localparam logic [WORD_W-1:0] LW_EOI        = 32'h0008_0000;

    typedef enum logic [KIND_W-1:0] {
        KIND_EXPOSE   = 2'd0,
        KIND_PENDING  = 2'd1,
        KIND_ENABLE   = 2'd2,
        KIND_PRIORITY = 2'd3
    } t_kind;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INJECTED    = 2'd0,
        ACT_DISCONTINUE = 2'd1,
        ACT_REFUSED     = 2'd2,
        ACT_ACCEPTED    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH,
        ST_RESP
    } t_state;

    typedef struct packed {
        t_kind              kind;
        logic [IDX_W-1:0]   index;
        logic [VALUE_W-1:0] value;
        logic [PROC_W-1:0]  proc_number;
    } t_req;

    typedef struct packed {
        t_action            action;
        logic [WORD_W-1:0]  list_word;
        logic [IDX_W-1:0]   chosen_index;
    } t_res;

    typedef struct packed {
        logic               feature_enable;
        logic [PRIO_W-1:0]  prio_limit;
        logic [BASE_W-1:0]  spi_base;
    } t_cfg;

endpackage

// ----- hw/rtl/vips_if.sv -----
// ----------------------------------------------------------------------------
// vips_if
// Valid/ready channels of the virtual interrupt priority select block.
// ----------------------------------------------------------------------------
interface vips_in_if;
    logic                         valid;
    logic                         ready;
    logic [vips_pkg::KIND_W-1:0]  kind;
    logic [vips_pkg::IDX_W-1:0]   index;
    logic [vips_pkg::VALUE_W-1:0] value;
    logic [vips_pkg::PROC_W-1:0]  proc_number;

    modport source (output valid, kind, index, value, proc_number, input ready);
    modport sink   (input valid, kind, index, value, proc_number, output ready);
endinterface

interface vips_out_if;
    logic                          valid;
    logic                          ready;
    logic [vips_pkg::ACTION_W-1:0] action;
    logic [vips_pkg::WORD_W-1:0]   list_word;
    logic [vips_pkg::IDX_W-1:0]    chosen_index;

    modport source (output valid, action, list_word, chosen_index, input ready);
    modport sink   (input valid, action, list_word, chosen_index, output ready);
endinterface

interface vips_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [vips_pkg::CFG_ADDR_W-1:0] addr;
    logic [vips_pkg::CFG_DATA_W-1:0] wdata;

    modport source (output valid, addr, wdata, input ready);
    modport sink   (input valid, addr, wdata, output ready);
endinterface

// ----- hw/rtl/vips_ram.sv -----
// ----------------------------------------------------------------------------
// vips_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module vips_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/vips_ctrl.sv -----
// ----------------------------------------------------------------------------
// vips_ctrl
// Request sequencer: applies updates, scans the priority RAM for exposes.
// ----------------------------------------------------------------------------
module vips_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  vips_pkg::t_cfg i_cfg,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  vips_pkg::t_req i_req,
    output logic           o_res_valid,
    input  logic           i_res_ready,
    output vips_pkg::t_res o_res
);

    localparam int NE = vips_pkg::NUM_ENTRIES;
    localparam int AW = vips_pkg::ENT_AW;
    localparam int CW = vips_pkg::CNT_W;
    localparam logic [vips_pkg::IDX_W:0] ENTRY_LIMIT = (vips_pkg::IDX_W + 1)'(NE);
    localparam logic [CW-1:0]            CNT_END     = CW'(NE);

    vips_pkg::t_state r_state, n_state;

    logic [NE-1:0] r_pending;
    logic [NE-1:0] r_enable;
    logic [NE-1:0] r_pvalid;
    logic [NE-1:0] r_live;

    logic [CW-1:0]                r_rd_cnt;
    logic                         r_cmp_vld;
    logic [AW-1:0]                r_cmp_idx;
    logic [vips_pkg::PRIO_W-1:0]  r_best;
    logic [AW-1:0]                r_win;
    logic                         r_found;
    vips_pkg::t_res               r_res;

    logic                        req_acc;
    logic                        in_range;
    logic                        expose_ok;
    logic [AW-1:0]               upd_idx;
    logic                        ram_we;
    logic                        ram_re;
    logic [AW-1:0]               ram_raddr;
    logic [vips_pkg::PRIO_W-1:0] ram_rdata;
    logic [vips_pkg::PRIO_W-1:0] cmp_prio;
    logic                        cmp_win;
    logic [vips_pkg::VID_W-1:0]  vid;
    vips_pkg::t_action           upd_action;

    assign req_acc   = i_req_valid && o_req_ready;
    assign in_range  = {1'b0, i_req.index} < ENTRY_LIMIT;
    assign expose_ok = i_cfg.feature_enable && (i_req.proc_number == '0);
    assign upd_idx   = i_req.index[AW-1:0];
    assign ram_raddr = r_rd_cnt[AW-1:0];
    assign cmp_prio  = r_pvalid[r_cmp_idx] ? ram_rdata : '0;
    assign cmp_win   = r_cmp_vld && r_live[r_cmp_idx] && (cmp_prio < r_best);
    assign vid       = {1'b0, i_cfg.spi_base} + vips_pkg::VID_W'(r_win);

    always_comb begin
        upd_action = vips_pkg::ACT_REFUSED;
        if (i_req.kind != vips_pkg::KIND_EXPOSE && in_range) begin
            upd_action = vips_pkg::ACT_ACCEPTED;
        end
    end

    vips_ram #(
        .DEPTH (NE),
        .WIDTH (vips_pkg::PRIO_W)
    ) u_prio_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (upd_idx),
        .i_wdata (i_req.value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            vips_pkg::ST_IDLE: begin
                if (req_acc) begin
                    if (i_req.kind == vips_pkg::KIND_EXPOSE && expose_ok) begin
                        n_state = vips_pkg::ST_SCAN;
                    end else begin
                        n_state = vips_pkg::ST_RESP;
                    end
                end
            end
            vips_pkg::ST_SCAN: begin
                if (r_rd_cnt == CNT_END && !r_cmp_vld) begin
                    n_state = vips_pkg::ST_FINISH;
                end
            end
            vips_pkg::ST_FINISH: begin
                n_state = vips_pkg::ST_RESP;
            end
            vips_pkg::ST_RESP: begin
                if (i_res_ready) begin
                    n_state = vips_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = vips_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_req_ready = 1'b0;
        o_res_valid = 1'b0;
        ram_re      = 1'b0;
        ram_we      = 1'b0;
        case (r_state)
            vips_pkg::ST_IDLE: begin
                o_req_ready = 1'b1;
                ram_we      = i_req_valid && (i_req.kind == vips_pkg::KIND_PRIORITY)
                              && in_range;
            end
            vips_pkg::ST_SCAN: begin
                ram_re = r_rd_cnt != CNT_END;
            end
            vips_pkg::ST_RESP: begin
                o_res_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= vips_pkg::ST_IDLE;
            r_pending <= '0;
            r_enable  <= '0;
            r_pvalid  <= '0;
        end else begin
            r_state <= n_state;
            if (req_acc && in_range) begin
                case (i_req.kind)
                    vips_pkg::KIND_PENDING:  r_pending[upd_idx] <= 1'b1;
                    vips_pkg::KIND_ENABLE:   r_enable[upd_idx]  <= i_req.value[0];
                    vips_pkg::KIND_PRIORITY: r_pvalid[upd_idx]  <= 1'b1;
                    default: begin
                    end
                endcase
            end
            if (r_state == vips_pkg::ST_FINISH && r_found) begin
                r_pending[r_win] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_live    <= r_pending & r_enable;
            r_best    <= i_cfg.prio_limit;
            r_found   <= 1'b0;
            r_rd_cnt  <= '0;
            r_cmp_vld <= 1'b0;
            r_res     <= '{action: upd_action, list_word: '0, chosen_index: '0};
        end
        if (r_state == vips_pkg::ST_SCAN) begin
            r_cmp_vld <= ram_re;
            r_cmp_idx <= ram_raddr;
            if (ram_re) begin
                r_rd_cnt <= r_rd_cnt + 1'b1;
            end
            if (cmp_win) begin
                r_best  <= cmp_prio;
                r_win   <= r_cmp_idx;
                r_found <= 1'b1;
            end
        end
        if (r_state == vips_pkg::ST_FINISH) begin
            if (r_found) begin
                r_res.action       <= vips_pkg::ACT_INJECTED;
                r_res.list_word    <= (vips_pkg::WORD_W'(r_best) << vips_pkg::LW_PRIO_SHIFT)
                                      | vips_pkg::LW_PENDING | vips_pkg::LW_EOI
                                      | vips_pkg::WORD_W'(vid);
                r_res.chosen_index <= vips_pkg::IDX_W'(r_win);
            end else begin
                r_res.action <= vips_pkg::ACT_DISCONTINUE;
            end
        end
    end

    assign o_res = r_res;

endmodule

// ----- hw/rtl/virtual_interrupt_priority_select.sv -----
// ----------------------------------------------------------------------------
// virtual_interrupt_priority_select
// Pending/enable/priority state for 32 virtual interrupts and priority pick.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  : requests. kind 0 exposes the best interrupt, kinds 1..3 set a
//           pending bit, write an enable bit or write a priority.
//   o_out : one response per request (action, list_word, chosen_index).
//   i_cfg : register writes (0 feature_enable, 1 priority limit, 2 spi_base),
//           always ready; write only while no request is in flight.
// Timing:
//   One request at a time. Update and refused requests: the response passes
//   through the RESP state and the output register, and the next request can
//   be taken in the same cycle as that response. Expose: the response waits
//   on the priority RAM scan, one entry read per cycle through its single
//   read port. The output register holds a response while o_out.ready is low;
//   the next request is still accepted and waits in the sequencer until it drains.
// Reset: synchronous, active low; config registers return to their defaults, all
//   pending/enable bits clear and every priority reads as zero.
// ----------------------------------------------------------------------------
module virtual_interrupt_priority_select (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vips_in_if.sink    i_in,
    vips_out_if.source o_out,
    vips_cfg_if.sink   i_cfg
);

    vips_pkg::t_cfg r_cfg;
    vips_pkg::t_req req;
    vips_pkg::t_res res;
    logic           res_valid;
    logic           res_ready;
    logic           req_ready;
    logic           r_out_valid;
    vips_pkg::t_res r_out;

    assign req = '{kind:        vips_pkg::t_kind'(i_in.kind),
                   index:       i_in.index,
                   value:       i_in.value,
                   proc_number: i_in.proc_number};

    assign i_in.ready  = req_ready;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.feature_enable <= 1'b0;
            r_cfg.prio_limit     <= vips_pkg::PRIO_MASK_RST;
            r_cfg.spi_base       <= vips_pkg::SPI_BASE_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.addr)
                vips_pkg::CFG_FEATURE_ENABLE: r_cfg.feature_enable <= i_cfg.wdata[0];
                vips_pkg::CFG_PRIO_LIMIT:
                    r_cfg.prio_limit <= i_cfg.wdata[vips_pkg::PRIO_W-1:0];
                vips_pkg::CFG_SPI_BASE:
                    r_cfg.spi_base <= i_cfg.wdata[vips_pkg::BASE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    vips_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_req_valid (i_in.valid),
        .o_req_ready (req_ready),
        .i_req       (req),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    assign res_ready = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.action       = r_out.action;
    assign o_out.list_word    = r_out.list_word;
    assign o_out.chosen_index = r_out.chosen_index;

endmodule

// ----- hw/rtl/vips_checker.sv -----
// ----------------------------------------------------------------------------
// vips_checker
// Port-level checks of the virtual interrupt priority select block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vips_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [vips_pkg::ACTION_W-1:0] i_action,
    input logic [vips_pkg::WORD_W-1:0]   i_list_word,
    input logic [vips_pkg::IDX_W-1:0]    i_chosen_index
);

    `VIPS_ASSERT_ALWAYS(a_rst_out_idle, i_clk, !i_rst_n |=> !i_out_valid, "response valid after reset")
    `VIPS_ASSERT(a_one_at_a_time, i_clk, i_rst_n, (i_in_valid && i_in_ready) |=> !i_in_ready, "request taken while busy")
    `VIPS_ASSERT(a_inject_word, i_clk, i_rst_n, (i_out_valid && i_action == vips_pkg::ACT_INJECTED) |-> (i_list_word[28] && i_list_word[19]), "injected word lacks state bits")
    `VIPS_ASSERT(a_other_zero, i_clk, i_rst_n, (i_out_valid && i_action != vips_pkg::ACT_INJECTED) |-> (i_list_word == '0 && i_chosen_index == '0), "non-injected response carries data")
    `VIPS_ASSERT(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_action) && $stable(i_list_word) && $stable(i_chosen_index)), "stalled response changed")

endmodule

bind virtual_interrupt_priority_select vips_checker u_vips_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_action       (o_out.action),
    .i_list_word    (o_out.list_word),
    .i_chosen_index (o_out.chosen_index)
);
